>>> src/cpb_pkg.sv
// Shared constants and controller-datapath interface types for the CSR pattern builder.
package cpb_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int MAX_ROWS    = 16;
  localparam int COLUMN_BITS = 16;

  localparam int ROW_W    = 4;
  localparam int COL_IN_W = 16;
  localparam int COL_W    = (COLUMN_BITS < COL_IN_W) ? COLUMN_BITS : COL_IN_W;
  localparam int CNT_W    = $clog2(MAX_ENTRIES + 1);
  localparam int POS_W    = 6;
  localparam int VALUE_W  = 16;
  localparam int CFG_W    = 5;

  localparam logic [CFG_W-1:0] ROWS_RESET = CFG_W'(16);

  typedef struct packed {
    logic load;
    logic arm;
    logic emit_col;
    logic start_rows;
    logic emit_row;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic col_pending;
    logic row_last;
  } sts_t;

endpackage

>>> src/coo_to_csr_pattern_builder.sv
// Top level of the coordinate to CSR pattern builder with its configuration register.
//
// The in_ channel takes one (row, column) coordinate per transfer; in_tlast marks
// the final coordinate of a set. Coordinates load one per cycle into a sorted
// store of up to 32 distinct entries; duplicates are ignored, and coordinates
// beyond capacity or with a row at or beyond rows_in_use are dropped.
// On the final transfer the block stops accepting input and emits on the out_
// channel the column index of each stored entry in order (out_tuser low), then
// min(rows_in_use, 16)+1 row offsets (out_tuser high), the last carrying out_tlast.
// The first result carries the dropped flag.
// Results leave one per cycle while the receiver does not stall, set by the
// single output register, with a gap between the last column and the first row
// offset; in_tready returns high as the last row offset is registered, so loading
// overlaps the wait for its transfer.
// A stalled receiver holds the output register and pauses the emit sequence.
// Reset empties the store, clears the dropped flag and sets rows_in_use to 16.
// rows_in_use is written through the cfg_ port at byte address 0.
module coo_to_csr_pattern_builder
  import cpb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // entry_row[3:0], entry_column[19:4], zero fill
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // position[5:0], item_value[21:6], dropped_any[22], zero fill
  output logic        out_tuser,  // item_kind[0]
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cmd_t cmd;
  sts_t sts;

  logic [CFG_W-1:0]   rows_in_use_r;
  logic [POS_W-1:0]   position;
  logic [VALUE_W-1:0] item_value;
  logic               dropped_any;
  logic               cfg_write;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[1:0] == 2'b00);
  assign cfg_prdata = {{(32 - CFG_W){1'b0}}, rows_in_use_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_in_use_r <= ROWS_RESET;
    end else if (cfg_write) begin
      rows_in_use_r <= cfg_pwdata[CFG_W-1:0];
    end
  end

  cpb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  cpb_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .rows_in_use (rows_in_use_r),
    .entry_row   (in_tdata[3:0]),
    .entry_column(in_tdata[19:4]),
    .item_kind   (out_tuser),
    .position    (position),
    .item_value  (item_value),
    .dropped_any (dropped_any),
    .run_end     (out_tlast)
  );

  assign out_tdata = {1'b0, dropped_any, item_value, position};

endmodule

>>> src/cpb_ctrl.sv
// Controller state machine sequencing load, column emit and row offset emit.
module cpb_ctrl
  import cpb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  input  logic in_tlast,
  output logic in_tready,
  output logic out_tvalid,
  input  logic out_tready,
  output cmd_t cmd,
  input  sts_t sts
);

  typedef enum logic [1:0] {
    S_LOAD,
    S_COL,
    S_ROW
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign in_tready  = (state_r == S_LOAD);

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      S_LOAD: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (in_tlast) begin
            cmd.arm   = 1'b1;
            state_nxt = S_COL;
          end
        end
      end
      S_COL: begin
        if (slot_free) begin
          if (sts.col_pending) begin
            cmd.emit_col  = 1'b1;
            out_valid_nxt = 1'b1;
          end else begin
            cmd.start_rows = 1'b1;
            state_nxt      = S_ROW;
          end
        end
      end
      S_ROW: begin
        if (slot_free) begin
          cmd.emit_row  = 1'b1;
          out_valid_nxt = 1'b1;
          if (sts.row_last) begin
            cmd.finish = 1'b1;
            state_nxt  = S_LOAD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> src/cpb_datapath.sv
// Sorted coordinate store, per-row counters, offset accumulator and result register.
module cpb_datapath
  import cpb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [CFG_W-1:0]   rows_in_use,
  input  logic [ROW_W-1:0]   entry_row,
  input  logic [COL_IN_W-1:0] entry_column,
  output logic               item_kind,
  output logic [POS_W-1:0]   position,
  output logic [VALUE_W-1:0] item_value,
  output logic               dropped_any,
  output logic               run_end
);

  logic [ROW_W-1:0] rows_r [MAX_ENTRIES];
  logic [COL_W-1:0] cols_r [MAX_ENTRIES];
  logic [ROW_W-1:0] rows_nxt [MAX_ENTRIES];
  logic [COL_W-1:0] cols_nxt [MAX_ENTRIES];
  logic [CNT_W-1:0] row_cnt_r [MAX_ROWS];
  logic [CNT_W-1:0] row_cnt_nxt [MAX_ROWS];

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             drop_r, drop_nxt;
  logic             first_r, first_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] running_r, running_nxt;

  logic             item_kind_r, dropped_any_r, run_end_r;
  logic [POS_W-1:0] position_r;
  logic [VALUE_W-1:0] item_value_r;

  logic [CFG_W-1:0]       eff_rows;
  logic [COL_W-1:0]       in_col;
  logic [ROW_W+COL_W-1:0] in_key;
  logic [MAX_ENTRIES-1:0] less, equal;
  logic                   dup, full, row_bad, insert;
  logic                   row_in_range;

  assign eff_rows = (rows_in_use > CFG_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : rows_in_use;
  assign in_col   = entry_column[COL_W-1:0];
  assign in_key   = {entry_row, in_col};

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      less[i]  = (CNT_W'(i) < count_r) && ({rows_r[i], cols_r[i]} < in_key);
      equal[i] = (CNT_W'(i) < count_r) && ({rows_r[i], cols_r[i]} == in_key);
    end
  end

  assign dup     = |equal;
  assign full    = (count_r == CNT_W'(MAX_ENTRIES));
  assign row_bad = ({1'b0, entry_row} >= eff_rows);
  assign insert  = cmd.load && !row_bad && !dup && !full;

  assign row_in_range     = (pos_r < POS_W'(eff_rows));
  assign sts.col_pending  = (count_r != '0);
  assign sts.row_last     = (pos_r == POS_W'(eff_rows));

  always_comb begin
    rows_nxt    = rows_r;
    cols_nxt    = cols_r;
    row_cnt_nxt = row_cnt_r;
    count_nxt   = count_r;
    drop_nxt    = drop_r;
    first_nxt   = first_r;
    pos_nxt     = pos_r;
    running_nxt = running_r;

    if (insert) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (!less[i]) begin
          if (i == 0 || less[(i > 0) ? i - 1 : 0]) begin
            rows_nxt[i] = entry_row;
            cols_nxt[i] = in_col;
          end else begin
            rows_nxt[i] = rows_r[(i > 0) ? i - 1 : 0];
            cols_nxt[i] = cols_r[(i > 0) ? i - 1 : 0];
          end
        end
      end
      for (int r = 0; r < MAX_ROWS; r++) begin
        if (entry_row == ROW_W'(r)) begin
          row_cnt_nxt[r] = row_cnt_r[r] + CNT_W'(1);
        end
      end
      count_nxt = count_r + CNT_W'(1);
    end
    if (cmd.load && (row_bad || (!dup && full))) begin
      drop_nxt = 1'b1;
    end
    if (cmd.arm) begin
      first_nxt = 1'b1;
      pos_nxt   = '0;
    end
    if (cmd.emit_col) begin
      for (int i = 0; i < MAX_ENTRIES - 1; i++) begin
        rows_nxt[i] = rows_r[i + 1];
        cols_nxt[i] = cols_r[i + 1];
      end
      count_nxt = count_r - CNT_W'(1);
      first_nxt = 1'b0;
      pos_nxt   = pos_r + POS_W'(1);
    end
    if (cmd.start_rows) begin
      pos_nxt     = '0;
      running_nxt = '0;
    end
    if (cmd.emit_row) begin
      first_nxt = 1'b0;
      pos_nxt   = pos_r + POS_W'(1);
      if (row_in_range) begin
        running_nxt = running_r + row_cnt_r[pos_r[ROW_W-1:0]];
      end
    end
    if (cmd.finish) begin
      drop_nxt = 1'b0;
      for (int r = 0; r < MAX_ROWS; r++) begin
        row_cnt_nxt[r] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rows_r <= rows_nxt;
    cols_r <= cols_nxt;
    if (cmd.emit_col) begin
      item_kind_r   <= 1'b0;
      position_r    <= pos_r;
      item_value_r  <= VALUE_W'(cols_r[0]);
      dropped_any_r <= first_r && drop_r;
      run_end_r     <= 1'b0;
    end else if (cmd.emit_row) begin
      item_kind_r   <= 1'b1;
      position_r    <= pos_r;
      item_value_r  <= VALUE_W'(running_r);
      dropped_any_r <= first_r && drop_r;
      run_end_r     <= sts.row_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= '{default: '0};
      count_r   <= '0;
      drop_r    <= 1'b0;
      first_r   <= 1'b0;
      pos_r     <= '0;
      running_r <= '0;
    end else begin
      row_cnt_r <= row_cnt_nxt;
      count_r   <= count_nxt;
      drop_r    <= drop_nxt;
      first_r   <= first_nxt;
      pos_r     <= pos_nxt;
      running_r <= running_nxt;
    end
  end

  assign item_kind   = item_kind_r;
  assign position    = position_r;
  assign item_value  = item_value_r;
  assign dropped_any = dropped_any_r;
  assign run_end     = run_end_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ENTRIES))
    else $error("Entry count exceeds the store depth.");

  a_col_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_col |-> count_r != '0)
    else $error("Column emitted from an empty store.");

  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_row |-> pos_r <= POS_W'(eff_rows))
    else $error("Row offset emitted beyond the row count.");

  a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (count_r == '0) && !drop_r)
    else $error("Store not cleared after the run.");

endmodule
